FILE: sv/medf_pkg.sv
package medf_pkg;

	localparam int DEF_WINDOW    = 5;
	localparam int DEF_MAX_WIDTH = 1024;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int FIFO_DEPTH = 8;

	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 768;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic valid;
		logic eof;
	} meta_t;

endpackage

FILE: sv/medf_rank.sv
module medf_rank import medf_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic   clk,
	input  logic   arst_n,
	input  pixel_t win [((WINDOW-1)/2*2+1)*((WINDOW-1)/2*2+1)],
	input  meta_t  meta_in,
	output pixel_t median,
	output meta_t  meta_out
);

	localparam int SIDE = (WINDOW - 1) / 2 * 2 + 1;
	localparam int AREA = SIDE * SIDE;
	localparam int RKW  = $clog2(AREA);
	localparam int MID  = AREA / 2;

	logic [AREA-1:0] lt_s1   [AREA];
	pixel_t          win_s1  [AREA];
	logic [RKW-1:0]  rank_s2 [AREA];
	pixel_t          win_s2  [AREA];
	meta_t           meta_s1, meta_s2;
	pixel_t          median_q;
	meta_t           meta_q;
	pixel_t          pick;

	// stage 1: pairwise order, ties broken by position
	always_ff @(posedge clk) begin
		for (int i = 0; i < AREA; i++) begin
			win_s1[i] <= win[i];
			for (int j = 0; j < AREA; j++) begin
				if (j == i)
					lt_s1[i][j] <= 1'b0;
				else
					lt_s1[i][j] <= (win[j] < win[i]) || ((win[j] == win[i]) && (j < i));
			end
		end
	end

	// stage 2: rank of each element
	always_ff @(posedge clk) begin
		for (int i = 0; i < AREA; i++) begin
			rank_s2[i] <= RKW'($countones(lt_s1[i]));
			win_s2[i]  <= win_s1[i];
		end
	end

	// ranks form a permutation, so exactly one element sits in the middle
	always_comb begin
		pick = '0;
		for (int i = 0; i < AREA; i++) begin
			if (rank_s2[i] == RKW'(MID))
				pick = pick | win_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		median_q <= pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_q  <= '0;
		end else begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_q  <= meta_s2;
		end
	end

	assign median   = median_q;
	assign meta_out = meta_q;

endmodule

FILE: sv/median_filter_5x5_replicate.sv
// Streaming 5x5 median filter with edge replication. Takes one item per clock
// while s_tready is high (pixels in raster order, tuser high for a flush tick)
// and gives one median per clock while m_tready is high, once two rows and two
// pixels have gone in; after the frame, flush items clock out the last two rows
// and two pixels, and tlast marks the final median. The image lives in a ring
// of eight row banks, each a synchronous memory of MAX_WIDTH bytes read and
// written once per item at the current column; one column of the window is
// read per item and a short line of column registers supplies the rest, so an
// item can enter every cycle unless the output queue is full. A small output
// queue lets input continue while results wait. Memory contents need no
// clearing after reset: every pixel read was written earlier in the same frame.
// The user must write width and height only while the block is idle; the
// block itself does not enforce it. Either write restarts the frame.
module median_filter_5x5_replicate import medf_pkg::*; #(
	parameter int WINDOW    = DEF_WINDOW,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] pixel
	input  logic                 s_tuser,   // [0] mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] median
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int R     = (WINDOW - 1) / 2;
	localparam int SIDE  = 2 * R + 1;
	localparam int AREA  = SIDE * SIDE;
	localparam int JW    = $clog2(SIDE);
	localparam int BW    = $clog2(SIDE);
	localparam int NB    = 1 << BW;
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int EW    = $clog2(MAX_WIDTH + 1);
	localparam int ROWW  = HEIGHT_W + 1;
	localparam int POSW  = HEIGHT_W + EW + 1;
	localparam int FPW   = $clog2(FIFO_DEPTH);
	localparam int FCW   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic   eof;
		pixel_t median;
	} result_t;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [EW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [POSW-1:0]     total, lag;

	logic [POSW-1:0] pos_q;
	logic [AW-1:0]   in_col_q, out_col_q;
	logic [ROWW-1:0] in_row_q;

	logic acc, lt_total, ignore, we, produce, fetch, eof, col_last, ocol_last;

	logic [BW-1:0] bank_c [SIDE];
	logic          fwd_c  [SIDE];
	logic [JW-1:0] jsel_c [SIDE];

	logic          fe_s1, ov_s1, eof_s1;
	logic [BW-1:0] bsel_s1 [SIDE];
	logic          fwd_s1  [SIDE];
	logic [JW-1:0] jsel_s1 [SIDE];
	pixel_t        pix_s1;
	pixel_t        rd_q    [NB];

	pixel_t newvec [SIDE];
	pixel_t hist_q [2*R][SIDE];
	pixel_t full   [SIDE][SIDE];
	pixel_t win_s2 [AREA];
	meta_t  meta_s2, meta_out;
	pixel_t med_out;

	result_t        fifo_q [FIFO_DEPTH];
	logic [FPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCW-1:0] fifo_cnt_q, pending_q;
	logic           m_acc;

	// effective frame size
	always_comb begin
		if (width_q == '0)
			w_eff = EW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = EW'(width_q);
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		total = POSW'(h_eff) * POSW'(w_eff);
		lag   = POSW'(R) * POSW'(w_eff) + POSW'(R);
	end

	assign acc       = s_tvalid & s_tready;
	assign lt_total  = pos_q < total;
	assign ignore    = lt_total && (s_tuser == MODE_FLUSH);
	assign we        = acc && lt_total && (s_tuser == MODE_PIXEL);
	assign produce   = !ignore && (pos_q >= lag);
	assign fetch     = !ignore && (in_row_q >= ROWW'(R));
	assign eof       = produce && (pos_q + POSW'(1) >= total + lag);
	assign col_last  = EW'(in_col_q) == w_eff - EW'(1);
	assign ocol_last = EW'(out_col_q) == w_eff - EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(RESET_WIDTH);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
		end else if (cfg_we || (acc && eof)) begin
			pos_q     <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
		end else if (acc && !ignore) begin
			pos_q <= pos_q + POSW'(1);
			if (col_last) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROWW'(1);
			end else begin
				in_col_q <= in_col_q + AW'(1);
			end
			if (produce)
				out_col_q <= ocol_last ? '0 : out_col_q + AW'(1);
		end
	end

	// vertical taps of the column fetched now, rows clamped into the frame
	always_comb begin
		logic signed [ROWW:0] rk;
		logic [ROWW-1:0]      rc;
		logic signed [EW+1:0] c;
		logic signed [EW+1:0] jv;
		for (int k = 0; k < SIDE; k++) begin
			rk = $signed({1'b0, in_row_q}) + (ROWW+1)'(k) - (ROWW+1)'(2 * R);
			if (rk < 0)
				rc = '0;
			else if (rk > $signed({2'b0, h_eff}) - 1)
				rc = ROWW'(h_eff) - ROWW'(1);
			else
				rc = rk[ROWW-1:0];
			bank_c[k] = rc[BW-1:0];
			fwd_c[k]  = we && (rc == in_row_q);
		end
		// which stored column feeds each window column, clamped at the side edges
		for (int d = 0; d < SIDE; d++) begin
			c = $signed({2'b0, EW'(out_col_q)}) + (EW+2)'(d) - (EW+2)'(R);
			if (c < 0)
				c = '0;
			else if (c > $signed({2'b0, w_eff}) - 1)
				c = $signed({2'b0, w_eff}) - 1;
			jv = c - $signed({2'b0, EW'(out_col_q)}) + (EW+2)'(R);
			jsel_c[d] = jv[JW-1:0];
		end
	end

	// row banks
	for (genvar b = 0; b < NB; b++) begin : g_bank
		pixel_t mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (we && (in_row_q[BW-1:0] == BW'(b)))
				mem[in_col_q] <= s_tdata;
			if (acc && fetch)
				rd_q[b] <= mem[in_col_q];
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= s_tdata;
		for (int k = 0; k < SIDE; k++) begin
			bsel_s1[k] <= bank_c[k];
			fwd_s1[k]  <= fwd_c[k];
			jsel_s1[k] <= jsel_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_s1  <= 1'b0;
			ov_s1  <= 1'b0;
			eof_s1 <= 1'b0;
		end else begin
			fe_s1  <= acc && fetch;
			ov_s1  <= acc && produce;
			eof_s1 <= eof;
		end
	end

	// newest column, with the pixel written in the same cycle forwarded
	always_comb begin
		for (int k = 0; k < SIDE; k++)
			newvec[k] = fwd_s1[k] ? pix_s1 : rd_q[bsel_s1[k]];
		for (int j = 0; j < 2 * R; j++)
			full[j] = hist_q[j];
		full[2*R] = newvec;
	end

	always_ff @(posedge clk) begin
		if (fe_s1) begin
			for (int j = 0; j < 2 * R; j++)
				hist_q[j] <= full[j+1];
		end
		if (ov_s1) begin
			for (int dy = 0; dy < SIDE; dy++)
				for (int dx = 0; dx < SIDE; dx++)
					win_s2[dy*SIDE+dx] <= full[jsel_s1[dx]][dy];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			meta_s2 <= '0;
		else
			meta_s2 <= '{valid: ov_s1, eof: eof_s1};
	end

	medf_rank #(
		.WINDOW(WINDOW)
	) u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.win     (win_s2),
		.meta_in (meta_s2),
		.median  (med_out),
		.meta_out(meta_out)
	);

	// output queue; input is held off once every slot is spoken for
	assign m_acc    = m_tvalid & m_tready;
	assign s_tready = pending_q < FCW'(FIFO_DEPTH);
	assign m_tvalid = fifo_cnt_q != '0;
	assign m_tdata  = fifo_q[rd_ptr_q].median;
	assign m_tlast  = fifo_q[rd_ptr_q].eof;

	always_ff @(posedge clk) begin
		if (meta_out.valid)
			fifo_q[wr_ptr_q] <= '{eof: meta_out.eof, median: med_out};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pending_q  <= '0;
		end else begin
			if (meta_out.valid)
				wr_ptr_q <= wr_ptr_q + FPW'(1);
			if (m_acc)
				rd_ptr_q <= rd_ptr_q + FPW'(1);
			fifo_cnt_q <= fifo_cnt_q + FCW'(meta_out.valid) - FCW'(m_acc);
			pending_q  <= pending_q + FCW'(acc && produce) - FCW'(m_acc);
		end
	end

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= FCW'(FIFO_DEPTH) && fifo_cnt_q <= pending_q)
		else $error("output queue overrun");

	a_out_has_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ov_s1 |-> fe_s1)
		else $error("median issued without a column fetch");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && eof && !cfg_we) |=> (pos_q == '0 && in_row_q == '0))
		else $error("frame position not cleared after last result");

endmodule
